### rtl/ftup_pkg.sv
package ftup_pkg;

	localparam int COORD_W   = 32;
	localparam int FRAC_W    = 16;
	localparam int MAX_TRI   = 64;
	localparam int SLOT_W    = 6;
	localparam int VSEL_W    = 2;
	localparam int ADDR_W    = SLOT_W + VSEL_W;
	localparam int MEM_DEPTH = MAX_TRI * 4;
	localparam int USE_W     = 7;
	localparam int TOL_W     = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int V_W       = COORD_W + 3;
	localparam int MUL_W     = V_W + 1;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int NUM_W     = 2 * COORD_W + 2;
	localparam int DIV_STEPS = NUM_W;
	localparam int QM_W      = COORD_W + 3;
	localparam int QV_W      = QM_W + 1;
	localparam int QZ_W      = COORD_W + 3;
	localparam int CM_W      = 56;
	localparam int CH_W      = CM_W / 2;
	localparam int SUM_W     = 2 * CM_W;
	localparam int ROOT_W    = SUM_W / 2;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int LEN_W     = ROOT_W + 2;
	localparam int STEP_W    = 7;

	localparam logic [CFG_IDX_W-1:0] REG_IN_USE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOL    = 2'd1;

	localparam logic [3:0] OP_NOP  = 4'd0;
	localparam logic [3:0] OP_NUMA = 4'd1;
	localparam logic [3:0] OP_NUMB = 4'd2;
	localparam logic [3:0] OP_CPA  = 4'd3;
	localparam logic [3:0] OP_CPB  = 4'd4;
	localparam logic [3:0] OP_RND  = 4'd5;
	localparam logic [3:0] OP_SQLL = 4'd6;
	localparam logic [3:0] OP_SQLH = 4'd7;
	localparam logic [3:0] OP_SQHH = 4'd8;
	localparam logic [3:0] OP_CLR  = 4'd9;

	localparam logic OPER_WRITE = 1'b0;
	localparam logic OPER_QUERY = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [V_W-1:0] dvec_t;

	typedef struct packed {
		coord_t z;
		coord_t y;
		coord_t x;
	} vec_t;

	typedef struct packed {
		dvec_t z;
		dvec_t y;
		dvec_t x;
	} dv_t;

	typedef struct packed {
		logic              wr;
		logic              cap;
		logic              rd_en;
		logic [VSEL_W-1:0] rd_sel;
		logic [SLOT_W-1:0] slot;
		logic [3:0]        op;
		logic [1:0]        comp;
		logic [1:0]        pair;
		logic              div_start;
		logic              div_step;
		logic              proj1;
		logic              proj2;
		logic              sq_start;
		logic              sq_step;
		logic              len_wr;
	} cmd_t;

	typedef struct packed {
		logic nz_zero;
		logic match;
	} stat_t;

endpackage

### rtl/first_triangle_under_point_top.sv
// Finds the first stored triangle lying under a query point.
// Input items on s_axis carry either a vector write (tuser[0] = 0) or a query
// (tuser[0] = 1). A write stores vertex a, b, c or the normal (tuser[2:1]) of
// slot tdata[5:0]; a query drops the point (x, y) vertically onto each
// triangle's plane, slot zero upward, and reports the first slot whose summed
// sub-triangle areas exceed its own area by less than the tolerance.
// Every input item yields exactly one result item on m_axis: tuser is the
// hit flag, tdata[5:0] the slot (zero on a miss or a write).
// Configuration: cfg_index 0 sets the number of slots searched, 1 sets the
// area tolerance; write only while the block is idle.
// A write, or a query with no slots in use, goes from acceptance straight to
// the result stage. A query works each slot searched in turn (a slot with a
// flat normal is skipped early) with one shared multiplier, a divider for the
// projection and a square root for each of the four cross-product lengths.
// One item is worked at a time.
// Reset clears the configuration to 0 slots and tolerance 66 and empties the
// output; the triangle table holds no defined value until written.
// When the receiver stalls, the result waits in the output register, the
// next item is still accepted, and its result waits until the register frees.
module first_triangle_under_point_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [103:0] s_axis_tdata,  // triangle_slot, vec_x, vec_y, vec_z, zero pad
	input  logic [2:0]   s_axis_tuser,  // operation, vector_select
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [7:0]   m_axis_tdata,  // triangle_index, zero pad
	output logic         m_axis_tuser,  // hit
	input  logic         cfg_we,
	input  logic [ftup_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ftup_pkg::CFG_W-1:0]     cfg_data
);

	logic [ftup_pkg::USE_W-1:0] in_use_q;
	logic [ftup_pkg::TOL_W-1:0] tol_q;
	ftup_pkg::cmd_t  cmd;
	ftup_pkg::stat_t stat;
	ftup_pkg::vec_t  in_vec;
	logic [ftup_pkg::SLOT_W-1:0] idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			tol_q    <= ftup_pkg::TOL_W'(66);
		end else if (cfg_we) begin
			unique case (cfg_index)
				ftup_pkg::REG_IN_USE: in_use_q <= cfg_data[ftup_pkg::USE_W-1:0];
				ftup_pkg::REG_TOL:    tol_q    <= cfg_data[ftup_pkg::TOL_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_vec.x = s_axis_tdata[37:6];
	assign in_vec.y = s_axis_tdata[69:38];
	assign in_vec.z = s_axis_tdata[101:70];
	assign m_axis_tdata = {2'b00, idx};

	ftup_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_oper  (s_axis_tuser[0]),
		.s_ready (s_axis_tready),
		.in_use  (in_use_q),
		.m_ready (m_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_hit   (m_axis_tuser),
		.m_idx   (idx),
		.cmd     (cmd),
		.stat    (stat)
	);

	ftup_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_slot (s_axis_tdata[5:0]),
		.in_vsel (s_axis_tuser[2:1]),
		.in_vec  (in_vec),
		.tol     (tol_q),
		.stat    (stat)
	);

endmodule

### rtl/ftup_dp.sv
module ftup_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ftup_pkg::cmd_t                 cmd,
	input  logic [ftup_pkg::SLOT_W-1:0]    in_slot,
	input  logic [ftup_pkg::VSEL_W-1:0]    in_vsel,
	input  ftup_pkg::vec_t                 in_vec,
	input  logic [ftup_pkg::TOL_W-1:0]     tol,
	output ftup_pkg::stat_t                stat
);

	localparam int CW = ftup_pkg::COORD_W;
	localparam int VW = ftup_pkg::V_W;
	localparam int MW = ftup_pkg::MUL_W;
	localparam int PW = ftup_pkg::PROD_W;
	localparam int NW = ftup_pkg::NUM_W;
	localparam int SW = ftup_pkg::SUM_W;
	localparam int RW = ftup_pkg::ROOT_W;
	localparam int LW = ftup_pkg::LEN_W;
	localparam int CMW = ftup_pkg::CM_W;
	localparam int CHW = ftup_pkg::CH_W;
	localparam logic [ftup_pkg::QM_W-1:0] QLIM = ftup_pkg::QM_W'(1) << (CW + 2);
	localparam logic signed [ftup_pkg::QV_W:0] ZLIM =
		(ftup_pkg::QV_W + 1)'((64'd1 << (CW + 1)) - 64'd1);

	ftup_pkg::vec_t mem [ftup_pkg::MEM_DEPTH];
	ftup_pkg::vec_t mem_q;
	logic rd_vld_s1;
	logic [ftup_pkg::VSEL_W-1:0] rd_sel_s1;
	logic [3:0] op_s1;

	ftup_pkg::vec_t a_q, b_q, c_q, n_q;
	ftup_pkg::coord_t px_q, py_q;
	logic signed [CW:0] dax_q, day_q;
	ftup_pkg::dv_t qa_q, qb_q, qc_q, ab_q, ac_q;
	logic signed [ftup_pkg::QZ_W-1:0] qz_q;

	logic signed [MW-1:0] ma, mb;
	logic signed [PW-1:0] p_q, acc_q, cross_q;
	logic signed [NW-1:0] num_q;
	logic [CMW-1:0] cmag_q;
	logic [SW-1:0] sum_q;

	logic [NW-1:0] dq_q;
	logic [CW-1:0] rem_q, dvs_q;
	logic qneg_q;

	logic [SW-1:0] rad_q;
	logic [RW+1:0] rem2_q;
	logic [RW-1:0] root_q;
	logic [RW-1:0] len_q [4];

	ftup_pkg::dv_t us, vs;
	logic signed [VW-1:0] ui, uj, vi, vj;
	logic signed [PW-1:0] rnd;
	logic [CW:0] dtrial;
	logic [ftup_pkg::QM_W-1:0] qm;
	logic signed [ftup_pkg::QV_W-1:0] qv;
	logic signed [ftup_pkg::QV_W:0] qzs;
	logic [RW+3:0] sr, st;
	logic [LW-1:0] lsum, lref;

	always_ff @(posedge clk) begin
		if (cmd.wr && ({1'b0, in_slot} < (ftup_pkg::SLOT_W + 1)'(ftup_pkg::MAX_TRI)))
			mem[{in_slot, in_vsel}] <= in_vec;
		if (cmd.rd_en)
			mem_q <= mem[{cmd.slot, cmd.rd_sel}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			op_s1     <= ftup_pkg::OP_NOP;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			op_s1     <= cmd.op;
		end
	end

	always_comb begin
		unique case (cmd.pair)
			2'd0: begin us = ab_q; vs = ac_q; end
			2'd1: begin us = qa_q; vs = qb_q; end
			2'd2: begin us = qb_q; vs = qc_q; end
			default: begin us = qc_q; vs = qa_q; end
		endcase
		unique case (cmd.comp)
			2'd0: begin ui = us.y; uj = us.z; vi = vs.y; vj = vs.z; end
			2'd1: begin ui = us.z; uj = us.x; vi = vs.z; vj = vs.x; end
			default: begin ui = us.x; uj = us.y; vi = vs.x; vj = vs.y; end
		endcase
	end

	always_comb begin
		unique case (cmd.op)
			ftup_pkg::OP_NUMA: begin ma = MW'(n_q.x); mb = MW'(dax_q); end
			ftup_pkg::OP_NUMB: begin ma = MW'(n_q.y); mb = MW'(day_q); end
			ftup_pkg::OP_CPA:  begin ma = MW'(ui); mb = MW'(vj); end
			ftup_pkg::OP_CPB:  begin ma = MW'(uj); mb = MW'(vi); end
			ftup_pkg::OP_SQLL: begin
				ma = MW'(cmag_q[CHW-1:0]); mb = MW'(cmag_q[CHW-1:0]);
			end
			ftup_pkg::OP_SQLH: begin
				ma = MW'(cmag_q[CMW-1:CHW]); mb = MW'(cmag_q[CHW-1:0]);
			end
			ftup_pkg::OP_SQHH: begin
				ma = MW'(cmag_q[CMW-1:CHW]); mb = MW'(cmag_q[CMW-1:CHW]);
			end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	always_comb begin
		rnd    = (cross_q + $signed(PW'(1) << (ftup_pkg::FRAC_W - 1))) >>> ftup_pkg::FRAC_W;
		dtrial = {rem_q, dq_q[NW-1]};
		qm     = (dq_q > NW'(QLIM)) ? QLIM : dq_q[ftup_pkg::QM_W-1:0];
		qv     = qneg_q ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
		qzs    = (ftup_pkg::QV_W + 1)'(a_q.z) + (ftup_pkg::QV_W + 1)'(qv);
		sr     = {rem2_q, rad_q[SW-1:SW-2]};
		st     = (RW + 4)'({root_q, 2'b01});
		lsum   = LW'(len_q[1]) + LW'(len_q[2]) + LW'(len_q[3]);
		lref   = LW'(len_q[0]) + LW'({tol, 1'b0});
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			px_q <= in_vec.x;
			py_q <= in_vec.y;
		end
		if (rd_vld_s1) begin
			unique case (rd_sel_s1)
				2'd0: begin
					a_q   <= mem_q;
					dax_q <= (CW + 1)'(mem_q.x) - (CW + 1)'(px_q);
					day_q <= (CW + 1)'(mem_q.y) - (CW + 1)'(py_q);
				end
				2'd1: b_q <= mem_q;
				2'd2: c_q <= mem_q;
				default: n_q <= mem_q;
			endcase
		end
		rd_sel_s1 <= cmd.rd_sel;
		p_q <= ma * mb;

		case (op_s1)
			ftup_pkg::OP_NUMA: acc_q <= p_q;
			ftup_pkg::OP_NUMB: num_q <= NW'(acc_q + p_q);
			ftup_pkg::OP_CPA:  acc_q <= p_q;
			ftup_pkg::OP_CPB:  cross_q <= acc_q - p_q;
			ftup_pkg::OP_RND:  cmag_q <= rnd[PW-1] ? CMW'(-rnd) : CMW'(rnd);
			ftup_pkg::OP_CLR:  sum_q <= '0;
			ftup_pkg::OP_SQLL: sum_q <= sum_q + SW'($unsigned(p_q));
			ftup_pkg::OP_SQLH: sum_q <= sum_q + (SW'($unsigned(p_q)) << (CHW + 1));
			ftup_pkg::OP_SQHH: sum_q <= sum_q + (SW'($unsigned(p_q)) << CMW);
			default: ;
		endcase

		if (cmd.div_start) begin
			dq_q   <= num_q[NW-1] ? NW'(-num_q) : NW'(num_q);
			rem_q  <= '0;
			dvs_q  <= n_q.z[CW-1] ? CW'(-n_q.z) : CW'(n_q.z);
			qneg_q <= num_q[NW-1] ^ n_q.z[CW-1];
		end else if (cmd.div_step) begin
			if (dtrial >= {1'b0, dvs_q}) begin
				rem_q <= CW'(dtrial - {1'b0, dvs_q});
				dq_q  <= {dq_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= dtrial[CW-1:0];
				dq_q  <= {dq_q[NW-2:0], 1'b0};
			end
		end

		if (cmd.proj1) begin
			if (qzs > ZLIM)
				qz_q <= ftup_pkg::QZ_W'(ZLIM);
			else if (qzs < -ZLIM)
				qz_q <= ftup_pkg::QZ_W'(-ZLIM);
			else
				qz_q <= ftup_pkg::QZ_W'(qzs);
		end
		if (cmd.proj2) begin
			qa_q.x <= VW'(dax_q);
			qa_q.y <= VW'(day_q);
			qa_q.z <= VW'(a_q.z) - VW'(qz_q);
			qb_q.x <= VW'(b_q.x) - VW'(px_q);
			qb_q.y <= VW'(b_q.y) - VW'(py_q);
			qb_q.z <= VW'(b_q.z) - VW'(qz_q);
			qc_q.x <= VW'(c_q.x) - VW'(px_q);
			qc_q.y <= VW'(c_q.y) - VW'(py_q);
			qc_q.z <= VW'(c_q.z) - VW'(qz_q);
			ab_q.x <= VW'(b_q.x) - VW'(a_q.x);
			ab_q.y <= VW'(b_q.y) - VW'(a_q.y);
			ab_q.z <= VW'(b_q.z) - VW'(a_q.z);
			ac_q.x <= VW'(c_q.x) - VW'(a_q.x);
			ac_q.y <= VW'(c_q.y) - VW'(a_q.y);
			ac_q.z <= VW'(c_q.z) - VW'(a_q.z);
		end

		if (cmd.sq_start) begin
			rad_q  <= sum_q;
			rem2_q <= '0;
			root_q <= '0;
		end else if (cmd.sq_step) begin
			rad_q <= rad_q << 2;
			if (sr >= st) begin
				rem2_q <= (RW + 2)'(sr - st);
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem2_q <= sr[RW+1:0];
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
		if (cmd.len_wr)
			len_q[cmd.pair] <= root_q;
	end

	assign stat.nz_zero = (n_q.z == '0);
	assign stat.match   = (lsum < lref);

endmodule

### rtl/ftup_ctrl.sv
module ftup_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_valid,
	input  logic                            s_oper,
	output logic                            s_ready,
	input  logic [ftup_pkg::USE_W-1:0]      in_use,
	input  logic                            m_ready,
	output logic                            m_valid,
	output logic                            m_hit,
	output logic [ftup_pkg::SLOT_W-1:0]     m_idx,
	output ftup_pkg::cmd_t                  cmd,
	input  ftup_pkg::stat_t                 stat
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD   = 4'd1;
	localparam logic [3:0] ST_NUM  = 4'd2;
	localparam logic [3:0] ST_DIV  = 4'd3;
	localparam logic [3:0] ST_PJ1  = 4'd4;
	localparam logic [3:0] ST_PJ2  = 4'd5;
	localparam logic [3:0] ST_CLR  = 4'd6;
	localparam logic [3:0] ST_LEN  = 4'd7;
	localparam logic [3:0] ST_DRN  = 4'd8;
	localparam logic [3:0] ST_SQS  = 4'd9;
	localparam logic [3:0] ST_SQR  = 4'd10;
	localparam logic [3:0] ST_NXT  = 4'd11;
	localparam logic [3:0] ST_CMP  = 4'd12;
	localparam logic [3:0] ST_SKP  = 4'd13;
	localparam logic [3:0] ST_DONE = 4'd14;

	localparam int UW = ftup_pkg::USE_W;
	localparam int TW = ftup_pkg::STEP_W;
	localparam logic [UW-1:0] TRI_LIM = UW'(ftup_pkg::MAX_TRI);

	logic [3:0] state_q;
	logic [UW-1:0] lim_q;
	logic [ftup_pkg::SLOT_W-1:0] slot_q;
	logic [TW-1:0] cnt_q;
	logic [1:0] comp_q, pair_q;
	logic [2:0] ph_q;
	logic res_hit_q;
	logic [ftup_pkg::SLOT_W-1:0] res_idx_q;
	logic out_vld_q, out_hit_q;
	logic [ftup_pkg::SLOT_W-1:0] out_idx_q;
	logic acc;
	logic out_load;
	logic [UW-1:0] slot_nx;
	logic [3:0] len_op;

	assign s_ready  = (state_q == ST_IDLE);
	assign acc      = s_valid && s_ready;
	assign out_load = (state_q == ST_DONE) && (!out_vld_q || m_ready);
	assign slot_nx  = {1'b0, slot_q} + UW'(1);
	assign m_valid  = out_vld_q;
	assign m_hit    = out_hit_q;
	assign m_idx    = out_idx_q;

	always_comb begin
		unique case (ph_q)
			3'd0: len_op = ftup_pkg::OP_CPA;
			3'd1: len_op = ftup_pkg::OP_CPB;
			3'd2: len_op = ftup_pkg::OP_RND;
			3'd4: len_op = ftup_pkg::OP_SQLL;
			3'd5: len_op = ftup_pkg::OP_SQLH;
			3'd6: len_op = ftup_pkg::OP_SQHH;
			default: len_op = ftup_pkg::OP_NOP;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.wr        = acc && (s_oper == ftup_pkg::OPER_WRITE);
		cmd.cap       = acc && (s_oper == ftup_pkg::OPER_QUERY);
		cmd.slot      = slot_q;
		cmd.rd_sel    = cnt_q[1:0];
		cmd.comp      = comp_q;
		cmd.pair      = pair_q;
		cmd.op        = ftup_pkg::OP_NOP;
		unique case (state_q)
			ST_RD:  cmd.rd_en = (cnt_q < TW'(4));
			ST_NUM: begin
				if (cnt_q == TW'(0))
					cmd.op = ftup_pkg::OP_NUMA;
				else if (cnt_q == TW'(1))
					cmd.op = ftup_pkg::OP_NUMB;
				cmd.div_start = (cnt_q == TW'(3));
			end
			ST_DIV: cmd.div_step = 1'b1;
			ST_PJ1: cmd.proj1 = 1'b1;
			ST_PJ2: cmd.proj2 = 1'b1;
			ST_CLR: cmd.op = ftup_pkg::OP_CLR;
			ST_LEN: cmd.op = len_op;
			ST_SQS: cmd.sq_start = 1'b1;
			ST_SQR: cmd.sq_step = 1'b1;
			ST_NXT: cmd.len_wr = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			lim_q     <= '0;
			slot_q    <= '0;
			cnt_q     <= '0;
			comp_q    <= '0;
			pair_q    <= '0;
			ph_q      <= '0;
			res_hit_q <= 1'b0;
			res_idx_q <= '0;
			out_vld_q <= 1'b0;
			out_hit_q <= 1'b0;
			out_idx_q <= '0;
		end else begin
			if (out_load)
				out_vld_q <= 1'b1;
			else if (out_vld_q && m_ready)
				out_vld_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						res_hit_q <= 1'b0;
						res_idx_q <= '0;
						slot_q    <= '0;
						cnt_q     <= '0;
						lim_q     <= (in_use > TRI_LIM) ? TRI_LIM : in_use;
						if (s_oper == ftup_pkg::OPER_WRITE || in_use == '0)
							state_q <= ST_DONE;
						else
							state_q <= ST_RD;
					end
				end
				ST_RD: begin
					cnt_q <= cnt_q + TW'(1);
					if (cnt_q == TW'(4)) begin
						cnt_q   <= '0;
						state_q <= ST_NUM;
					end
				end
				ST_NUM: begin
					cnt_q <= cnt_q + TW'(1);
					if (cnt_q == TW'(0) && stat.nz_zero)
						state_q <= ST_SKP;
					else if (cnt_q == TW'(3)) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + TW'(1);
					if (cnt_q == TW'(ftup_pkg::DIV_STEPS - 1))
						state_q <= ST_PJ1;
				end
				ST_PJ1: state_q <= ST_PJ2;
				ST_PJ2: begin
					pair_q  <= '0;
					state_q <= ST_CLR;
				end
				ST_CLR: begin
					comp_q  <= '0;
					ph_q    <= '0;
					state_q <= ST_LEN;
				end
				ST_LEN: begin
					ph_q <= ph_q + 3'd1;
					if (ph_q == 3'd6) begin
						ph_q <= '0;
						if (comp_q == 2'd2)
							state_q <= ST_DRN;
						else
							comp_q <= comp_q + 2'd1;
					end
				end
				ST_DRN: state_q <= ST_SQS;
				ST_SQS: begin
					cnt_q   <= '0;
					state_q <= ST_SQR;
				end
				ST_SQR: begin
					cnt_q <= cnt_q + TW'(1);
					if (cnt_q == TW'(ftup_pkg::SQRT_STEPS - 1))
						state_q <= ST_NXT;
				end
				ST_NXT: begin
					if (pair_q == 2'd3)
						state_q <= ST_CMP;
					else begin
						pair_q  <= pair_q + 2'd1;
						state_q <= ST_CLR;
					end
				end
				ST_CMP: begin
					if (stat.match) begin
						res_hit_q <= 1'b1;
						res_idx_q <= slot_q;
						state_q   <= ST_DONE;
					end else
						state_q <= ST_SKP;
				end
				ST_SKP: begin
					cnt_q <= '0;
					if (slot_nx >= lim_q)
						state_q <= ST_DONE;
					else begin
						slot_q  <= slot_nx[ftup_pkg::SLOT_W-1:0];
						state_q <= ST_RD;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						out_hit_q <= res_hit_q;
						out_idx_q <= res_idx_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && res_hit_q) |-> ({1'b0, res_idx_q} < lim_q))
		else $error("hit slot outside searched range");
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |-> ({1'b0, slot_q} < lim_q))
		else $error("slot read beyond searched range");
	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && s_oper == ftup_pkg::OPER_WRITE) |=> (state_q == ST_DONE && !res_hit_q))
		else $error("write item did not produce a miss result");
	a_sqrt_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NXT) |-> ($past(state_q) == ST_SQR))
		else $error("length stored without square root");
`endif

endmodule
